// ===== rtl/core/bhcc_pkg.sv =====
// Shared types and constants for the hall commutation controller.
`timescale 1ns / 1ps
`default_nettype none
package bhcc_pkg;
    localparam int unsigned HISTORY_DEPTH = 8;
    localparam int unsigned DUTY_W = 11;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned TS_W = 32;
    localparam int unsigned SUM_W = 36;
    localparam int unsigned GATE_W = 6;
    localparam logic [SUM_W-1:0] SPEED_NUMERATOR = SUM_W'(15000000);
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;
    localparam logic [GATE_W-1:0] GATES_ALL_LOW = 6'h2A;

    localparam logic [1:0] REQ_EDGE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    localparam logic [2:0] CFG_START_DUTY = 3'd0;
    localparam logic [2:0] CFG_TARGET_DUTY = 3'd1;
    localparam logic [2:0] CFG_DUTY_INC = 3'd2;
    localparam logic [2:0] CFG_LOW_CMP = 3'd3;
    localparam logic [2:0] CFG_DEBOUNCE = 3'd4;
    localparam logic [2:0] CFG_STALL = 3'd5;
    localparam logic [2:0] CFG_REVERSE = 3'd6;
    localparam logic [2:0] CFG_SPEED_LIMIT = 3'd7;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // latch input word and run front part
        logic sum_step;  // accumulate one interval ring entry
        logic div_start; // begin division
        logic div_step;  // one quotient bit
        logic spd_store; // store speed, restart accumulation
        logic avg_step;  // accumulate one speed ring entry
        logic finish;    // stall check, ramp, commutation, output
    } bhcc_cmd_t;

    typedef struct packed {
        logic speed_due; // tick with fresh interval
        logic sum_zero;
    } bhcc_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/bldc_hall_commutation_controller_unit.sv =====
// Top level of the six-step hall commutation controller.
`timescale 1ns / 1ps
`default_nettype none
// One word in, one word out. Hall edges, start and stop skip the ring scans;
// a control tick with a fresh interval scans the interval ring and, unless the
// sum is zero, runs the bit-serial 36-bit speed divider and the speed ring scan. A new word is
// taken only after the previous result has been taken.
module bldc_hall_commutation_controller_unit
    import bhcc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_req_type,
    input  wire logic [2:0]        s_hall_code,
    input  wire logic [TS_W-1:0]   s_timestamp,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [GATE_W-1:0]      m_gate_enables,
    output logic [DUTY_W-1:0]      m_compare_a,
    output logic [DUTY_W-1:0]      m_compare_b,
    output logic [DUTY_W-1:0]      m_compare_c,
    output logic [SPEED_W-1:0]     m_speed_rpm,
    output logic                   m_motor_running,
    output logic [DUTY_W-1:0]      m_applied_duty,
    output logic                   m_edge_accepted,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    bhcc_cmd_t cmd;
    bhcc_stat_t stat;

    bhcc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    bhcc_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_req_type(s_req_type), .s_hall_code(s_hall_code), .s_timestamp(s_timestamp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_gate_enables(m_gate_enables), .m_compare_a(m_compare_a),
        .m_compare_b(m_compare_b), .m_compare_c(m_compare_c),
        .m_speed_rpm(m_speed_rpm), .m_motor_running(m_motor_running),
        .m_applied_duty(m_applied_duty), .m_edge_accepted(m_edge_accepted)
    );
endmodule
`default_nettype wire

// ===== rtl/core/bhcc_ctrl.sv =====
// Sequencing state machine for the hall commutation controller.
`timescale 1ns / 1ps
`default_nettype none
module bhcc_ctrl
    import bhcc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  bhcc_stat_t      stat,
    output bhcc_cmd_t       cmd
);
    localparam int unsigned CW = $clog2(SUM_W + HISTORY_DEPTH + 1) + 1;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_CHECK = 3'd1, ST_SUM = 3'd2,
        ST_DIVS = 3'd3, ST_DIV = 3'd4, ST_AVG = 3'd5, ST_FIN = 3'd6, ST_OUT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cnt_next = '0;
                state_next = stat.speed_due ? ST_SUM : ST_FIN;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(HISTORY_DEPTH - 1)) state_next = ST_DIVS;
            end
            ST_DIVS: begin
                cnt_next = '0;
                if (stat.sum_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SUM_W - 1)) begin
                    cnt_next = '0;
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (cnt_reg == '0) cmd.spd_store = 1'b1;
                else cmd.avg_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(HISTORY_DEPTH)) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/bhcc_dp.sv =====
// Datapath: rings, serial divider, ramp and commutation tables.
`timescale 1ns / 1ps
`default_nettype none
module bhcc_dp
    import bhcc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  bhcc_cmd_t              cmd,
    output bhcc_stat_t             stat,
    input  wire logic [1:0]        s_req_type,
    input  wire logic [2:0]        s_hall_code,
    input  wire logic [TS_W-1:0]   s_timestamp,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output logic [GATE_W-1:0]      m_gate_enables,
    output logic [DUTY_W-1:0]      m_compare_a,
    output logic [DUTY_W-1:0]      m_compare_b,
    output logic [DUTY_W-1:0]      m_compare_c,
    output logic [SPEED_W-1:0]     m_speed_rpm,
    output logic                   m_motor_running,
    output logic [DUTY_W-1:0]      m_applied_duty,
    output logic                   m_edge_accepted
);
    localparam int unsigned PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned AW = SPEED_W + PW + 1;

    logic [DUTY_W-1:0] start_duty_reg, target_duty_reg, duty_inc_reg, low_cmp_reg;
    logic [15:0] debounce_reg, speed_limit_reg;
    logic [31:0] stall_reg;
    logic reverse_reg;

    logic running_reg, fresh_reg;
    logic [DUTY_W-1:0] duty_reg, cmp_reg [3];
    logic [GATE_W-1:0] gate_reg;
    logic [TS_W-1:0] last_edge_reg;
    logic [TS_W-1:0] iring_reg [HISTORY_DEPTH];
    logic [SPEED_W-1:0] sring_reg [HISTORY_DEPTH];
    logic [PW-1:0] iptr_reg, sptr_reg, scan_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [1:0] req_reg;
    logic [2:0] code_reg;
    logic [TS_W-1:0] ts_reg;
    logic acc_reg, comm_reg;
    logic [SUM_W-1:0] sum_reg, quo_reg, num_reg;
    logic [SUM_W:0] rem_reg;
    logic [AW-1:0] avg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_duty_reg <= 11'd152; target_duty_reg <= 11'd913;
            duty_inc_reg <= 11'd7; low_cmp_reg <= 11'd1447;
            debounce_reg <= 16'd100; stall_reg <= 32'd1000000;
            reverse_reg <= 1'b0; speed_limit_reg <= 16'd5000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_DUTY: start_duty_reg <= cfg_data[DUTY_W-1:0];
                CFG_TARGET_DUTY: target_duty_reg <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_INC: duty_inc_reg <= cfg_data[DUTY_W-1:0];
                CFG_LOW_CMP: low_cmp_reg <= cfg_data[DUTY_W-1:0];
                CFG_DEBOUNCE: debounce_reg <= cfg_data[15:0];
                CFG_STALL: stall_reg <= cfg_data;
                CFG_REVERSE: reverse_reg <= cfg_data[0];
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [TS_W-1:0] delta, in_delta;
    logic [SUM_W:0] rem_sh;
    logic [DUTY_W:0] duty_sum;
    logic [SPEED_W-1:0] mean;
    logic ramp;
    assign in_delta = s_timestamp - last_edge_reg;
    assign delta = ts_reg - last_edge_reg;
    assign stat.speed_due = (req_reg == REQ_TICK) && fresh_reg;
    assign stat.sum_zero = (sum_reg == '0);
    assign rem_sh = {rem_reg[SUM_W-1:0], num_reg[SUM_W-1]};
    assign duty_sum = {1'b0, duty_reg} + {1'b0, duty_inc_reg};
    assign mean = SPEED_W'(avg_reg >> PW);
    assign ramp = (req_reg == REQ_TICK) && running_reg && (duty_reg < target_duty_reg);

    // commutation from stored state
    logic [1:0] hi, lo;
    logic pair;
    always_comb begin
        hi = 2'd0; lo = 2'd0; pair = 1'b1;
        case ({reverse_reg, code_reg})
            4'b0101: begin hi = 2'd0; lo = 2'd1; end
            4'b0100: begin hi = 2'd0; lo = 2'd2; end
            4'b0110: begin hi = 2'd1; lo = 2'd2; end
            4'b0010: begin hi = 2'd1; lo = 2'd0; end
            4'b0011: begin hi = 2'd2; lo = 2'd0; end
            4'b0001: begin hi = 2'd2; lo = 2'd1; end
            4'b1101: begin hi = 2'd2; lo = 2'd0; end
            4'b1100: begin hi = 2'd2; lo = 2'd1; end
            4'b1110: begin hi = 2'd0; lo = 2'd1; end
            4'b1010: begin hi = 2'd0; lo = 2'd2; end
            4'b1011: begin hi = 2'd1; lo = 2'd2; end
            4'b1001: begin hi = 2'd1; lo = 2'd0; end
            default: pair = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0; fresh_reg <= 1'b0; duty_reg <= 11'd152;
            for (int i = 0; i < 3; i++) cmp_reg[i] <= '0;
            gate_reg <= '0; last_edge_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                iring_reg[i] <= '0; sring_reg[i] <= '0;
            end
            iptr_reg <= '0; sptr_reg <= '0; speed_reg <= '0;
            acc_reg <= 1'b0; comm_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                acc_reg <= 1'b0; comm_reg <= 1'b0;
                case (s_req_type)
                    REQ_EDGE: if (in_delta >= TS_W'(debounce_reg)) begin
                        acc_reg <= 1'b1; comm_reg <= 1'b1;
                        iring_reg[iptr_reg] <= in_delta;
                        iptr_reg <= (iptr_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : iptr_reg + 1'b1;
                        last_edge_reg <= s_timestamp;
                        fresh_reg <= 1'b1;
                    end
                    REQ_TICK: ;
                    REQ_START: if (!running_reg) begin
                        running_reg <= 1'b1; duty_reg <= start_duty_reg; comm_reg <= 1'b1;
                    end
                    default: if (running_reg) begin
                        running_reg <= 1'b0; comm_reg <= 1'b1;
                    end
                endcase
            end
            if (cmd.spd_store) begin
                sring_reg[sptr_reg] <= (quo_reg > SUM_W'(SPEED_MAX)) ? SPEED_MAX
                                                                    : quo_reg[SPEED_W-1:0];
                sptr_reg <= (sptr_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : sptr_reg + 1'b1;
            end
            if (cmd.finish) begin
                if (stat.speed_due) begin
                    fresh_reg <= 1'b0;
                    if (!stat.sum_zero)
                        speed_reg <= (mean > speed_limit_reg || !running_reg) ? '0 : mean;
                end
                if (req_reg == REQ_TICK && delta > stall_reg) begin
                    speed_reg <= '0;
                    for (int i = 0; i < HISTORY_DEPTH; i++) begin
                        iring_reg[i] <= '0; sring_reg[i] <= '0;
                    end
                end
                if (ramp)
                    duty_reg <= (duty_sum > {1'b0, target_duty_reg}) ? target_duty_reg
                                                                   : duty_sum[DUTY_W-1:0];
                if (comm_reg || ramp) begin
                    if (!running_reg) begin
                        for (int i = 0; i < 3; i++) cmp_reg[i] <= low_cmp_reg;
                        gate_reg <= GATES_ALL_LOW;
                    end else if (pair) begin
                        cmp_reg[hi] <= ramp ? ((duty_sum > {1'b0, target_duty_reg})
                            ? target_duty_reg : duty_sum[DUTY_W-1:0]) : duty_reg;
                        cmp_reg[lo] <= low_cmp_reg;
                        gate_reg <= GATE_W'((6'd1 << {hi, 1'b0}) | (6'd2 << {lo, 1'b0}));
                    end else begin
                        gate_reg <= '0;
                    end
                end
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type; code_reg <= s_hall_code; ts_reg <= s_timestamp;
            sum_reg <= '0; scan_reg <= '0;
        end
        if (cmd.sum_step) begin
            sum_reg <= sum_reg + SUM_W'(iring_reg[scan_reg]);
            scan_reg <= (scan_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : scan_reg + 1'b1;
        end
        if (cmd.div_start) begin
            num_reg <= SPEED_NUMERATOR; rem_reg <= '0; quo_reg <= '0;
        end
        if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            if (rem_sh >= {1'b0, sum_reg}) begin
                rem_reg <= rem_sh - {1'b0, sum_reg};
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.spd_store) begin
            avg_reg <= '0; scan_reg <= '0;
        end
        if (cmd.avg_step) begin
            avg_reg <= avg_reg + AW'(sring_reg[scan_reg]);
            scan_reg <= (scan_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : scan_reg + 1'b1;
        end
    end

    assign m_gate_enables = gate_reg;
    assign m_compare_a = cmp_reg[0];
    assign m_compare_b = cmp_reg[1];
    assign m_compare_c = cmp_reg[2];
    assign m_speed_rpm = speed_reg;
    assign m_motor_running = running_reg;
    assign m_applied_duty = duty_reg;
    assign m_edge_accepted = acc_reg;
endmodule
`default_nettype wire
